### rtl/core/price_sorted_record_table_macros.svh
// Assertion macros for the price sorted record table checker.
// Depends on nothing; taken in by the checker file.
`ifndef PRICE_SORTED_RECORD_TABLE_MACROS_SVH
`define PRICE_SORTED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSRT_ASSERT_NOW(name, clk, rst_n, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("psrt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSRT_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("psrt check failed");

`endif

### rtl/core/psrt_pkg.sv
// Shared widths, codes and types of the price sorted record table.
// Depends on nothing; the interface, cell, chain, top-level and checker files import it.
package psrt_pkg;

  localparam int DEPTH_DEF = 32;

  localparam int MODE_W    = 3;
  localparam int PRICE_W   = 32;
  localparam int ROOMS_W   = 4;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 7;
  localparam int TIME_W    = 32;
  localparam int ID_W      = 15;
  localparam int DAYS_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int REMOVED_W = 6;
  localparam int DETAIL_W  = ROOMS_W + DAY_W + MONTH_W + YEAR_W;
  localparam int WIN_W     = 33;
  localparam int AGE_W     = TIME_W + 2;

  localparam int SECS_PER_DAY = 24 * 60 * 60;
  localparam logic [ID_W-1:0] ID_MAX = ID_W'(32767);

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RM_ID   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RM_AGE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_UP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_DN = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DROP,
    OP_FROM_LEFT,
    OP_FROM_RIGHT,
    OP_MARK_ID,
    OP_MARK_AGE
  } cell_op_t;

  typedef struct packed {
    logic                      mark;
    logic signed [PRICE_W-1:0] price;
    logic [ID_W-1:0]           id;
    logic [TIME_W-1:0]         stamp;
    logic [DETAIL_W-1:0]       detail;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    logic     clr_mark;
  } cmd_t;

  typedef struct packed {
    entry_t            rec;
    logic [ID_W-1:0]   target;
    logic [TIME_W-1:0] now;
    logic [WIN_W-1:0]  window;
  } bcast_t;

endpackage

### rtl/core/psrt_if.sv
// Valid/ready channel interfaces for the table's command and result words.
// Depends on psrt_pkg.
interface psrt_in_if import psrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [PRICE_W-1:0] price;
  logic [ROOMS_W-1:0]        rooms;
  logic [DAY_W-1:0]          entry_day;
  logic [MONTH_W-1:0]        entry_month;
  logic [YEAR_W-1:0]         entry_year;
  logic [TIME_W-1:0]         now_time;
  logic [ID_W-1:0]           target_id;
  logic [DAYS_W-1:0]         days;

  modport source (output valid, mode, price, rooms, entry_day, entry_month, entry_year,
                  now_time, target_id, days, input ready);
  modport sink (input valid, mode, price, rooms, entry_day, entry_month, entry_year,
                now_time, target_id, days, output ready);
endinterface

interface psrt_out_if import psrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [ID_W-1:0]           out_id;
  logic signed [PRICE_W-1:0] out_price;
  logic [ROOMS_W-1:0]        out_rooms;
  logic [DAY_W-1:0]          out_day;
  logic [MONTH_W-1:0]        out_month;
  logic [YEAR_W-1:0]         out_year;
  logic [TIME_W-1:0]         out_stamp;
  logic [REMOVED_W-1:0]      removed_count;
  logic                      is_last;

  modport source (output valid, status, out_id, out_price, out_rooms, out_day, out_month,
                  out_year, out_stamp, removed_count, is_last, input ready);
  modport sink (input valid, status, out_id, out_price, out_rooms, out_day, out_month,
                out_year, out_stamp, removed_count, is_last, output ready);
endinterface

### rtl/core/psrt_cell.sv
// One table slot: a record plus a mark bit, updated from its neighbors or the broadcast.
// Depends on psrt_pkg.
module psrt_cell import psrt_pkg::*; (
  input  logic   clk,
  input  cmd_t   cmd,
  input  bcast_t bc,
  input  logic   valid,
  input  entry_t left_i,
  input  entry_t right_i,
  input  logic   after_i,
  input  logic   hit_i,
  output logic   after_o,
  output logic   hit_o,
  output entry_t q
);

  entry_t            q_r;
  entry_t            q_nxt;
  logic [AGE_W-1:0]  age;
  logic              young;

  // at or past the insert point: empty slot or strictly larger key
  assign after_o = after_i | ~valid | ($signed(q_r.price) > $signed(bc.rec.price));
  assign hit_o   = hit_i | (valid & q_r.mark);

  assign age   = {2'b00, bc.now} - {2'b00, q_r.stamp};
  assign young = $signed(age) <= $signed({1'b0, bc.window});

  always_comb begin
    q_nxt = q_r;
    case (cmd.op)
      OP_INSERT: begin
        if (after_o) begin
          q_nxt = after_i ? left_i : bc.rec;
        end
      end
      OP_DROP: begin
        if (hit_o) begin
          q_nxt = right_i;
        end
        if (cmd.clr_mark) begin
          q_nxt.mark = 1'b0;
        end
      end
      OP_FROM_LEFT:  q_nxt = left_i;
      OP_FROM_RIGHT: q_nxt = right_i;
      OP_MARK_ID:    q_nxt.mark = valid & (q_r.id == bc.target);
      OP_MARK_AGE:   q_nxt.mark = valid & young;
      default:       q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

### rtl/core/psrt_chain.sv
// Row of table slots wired as a ring, with insert and delete prefix chains.
// Depends on psrt_pkg and psrt_cell.
module psrt_chain import psrt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  cmd_t                       cmd,
  input  bcast_t                     bc,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  output entry_t                     head,
  output entry_t                     tail,
  output logic                       any_mark
);

  localparam int CW = $clog2(DEPTH + 1);

  entry_t           cell_q [DEPTH];
  logic [DEPTH-1:0] after_c;
  logic [DEPTH:0]   hit_c;

  assign after_c[0] = 1'b0;
  assign hit_c[0]   = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int L = (i == 0) ? DEPTH - 1 : i - 1;
    localparam int R = (i == DEPTH - 1) ? 0 : i + 1;
    entry_t left_in;
    entry_t right_in;
    logic   slot_valid;

    assign slot_valid = count > CW'(i);
    assign left_in    = cell_q[L];
    // last slot closes the ring only while rotating toward the head; otherwise an empty record
    assign right_in   = (i == DEPTH - 1 && cmd.op != OP_FROM_RIGHT) ? '0 : cell_q[R];

    if (i < DEPTH - 1) begin : g_mid
      psrt_cell u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .bc      (bc),
        .valid   (slot_valid),
        .left_i  (left_in),
        .right_i (right_in),
        .after_i (after_c[i]),
        .hit_i   (hit_c[i]),
        .after_o (after_c[i+1]),
        .hit_o   (hit_c[i+1]),
        .q       (cell_q[i])
      );
    end else begin : g_end
      psrt_cell u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .bc      (bc),
        .valid   (slot_valid),
        .left_i  (left_in),
        .right_i (right_in),
        .after_i (after_c[i]),
        .hit_i   (hit_c[i]),
        .after_o (),
        .hit_o   (hit_c[i+1]),
        .q       (cell_q[i])
      );
    end
  end

  assign head     = cell_q[0];
  assign tail     = cell_q[DEPTH-1];
  assign any_mark = hit_c[DEPTH];

endmodule

### rtl/core/price_sorted_record_table.sv
// Price sorted record table: top level with command sequencer and result register.
// Depends on psrt_pkg, psrt_if and psrt_chain.
//
// Usage: command words arrive on in_ch (valid/ready); result words leave on out_ch.
// The table holds up to DEPTH records in a ring of slots, ascending by price.
// - Insert: one result (assigned id, or table full). The result word is loaded from
//   S_RESP once the result register is free; the next command is taken after that.
// - Remove by id: one result (ok or id not found), through S_DROP and then S_RESP.
// - Remove recent: mark all young slots in one pass, then drop one marked slot per
//   cycle; one result with the count of entries removed, loaded from S_RESP once
//   the purge finds no marked slot left.
// - Read up / read down: the ring rotates DEPTH steps past the head or tail slot,
//   one step per cycle unless a live record waits for the result register,
//   emitting each live record; is_last marks the final word. The first word loads
//   when the first live record reaches the tap. An empty table gives a single
//   empty-status word. Receiver stalls lengthen the command.
// Rate: one command at a time; in_ch.ready is high only between commands, and the
// result register lets a new command in while the last result is still waiting.
// Receiver stall: the ring holds while a live record waits for the result register.
// Reset (synchronous, active low): table empty, next id 1, no result pending.
// Unused mode codes are taken and dropped without a result.
module price_sorted_record_table import psrt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  psrt_in_if.sink    in_ch,
  psrt_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_AGE,
    S_PURGE,
    S_READ,
    S_RESP
  } state_t;

  state_t                    state_r;
  logic [CW-1:0]             count_r;
  logic [ID_W-1:0]           next_id_r;
  logic [WIN_W-1:0]          window_r;
  logic [TIME_W-1:0]         now_r;
  logic [STATUS_W-1:0]       resp_status_r;
  logic [ID_W-1:0]           resp_id_r;
  logic [CW-1:0]             purge_cnt_r;
  logic [RW-1:0]             rot_r;
  logic [CW-1:0]             emit_r;
  logic                      desc_r;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [ID_W-1:0]           out_id_r;
  logic signed [PRICE_W-1:0] out_price_r;
  logic [DETAIL_W-1:0]       out_detail_r;
  logic [TIME_W-1:0]         out_stamp_r;
  logic [REMOVED_W-1:0]      out_removed_r;
  logic                      out_last_r;

  logic   in_fire;
  logic   out_free;
  logic   out_load;
  logic   full;
  logic   tap_valid;
  logic   read_step;
  entry_t head;
  entry_t tail;
  entry_t tap;
  logic   any_mark;
  cmd_t   cmd;
  bcast_t bc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign out_free    = ~out_valid_r | out_ch.ready;
  assign full        = (count_r == CW'(DEPTH));

  // read up taps the head slot, read down the tail slot; rotation count tells
  // which original slot sits at the tap
  assign tap       = desc_r ? tail : head;
  assign tap_valid = desc_r ? ((CW'(DEPTH - 1) - CW'(rot_r)) < count_r)
                            : (CW'(rot_r) < count_r);
  assign read_step = (state_r == S_READ) & (out_free | ~tap_valid);

  // a new result word enters the output register this cycle
  assign out_load  = (read_step & tap_valid) | ((state_r == S_RESP) & out_free);

  // broadcast to every slot
  always_comb begin
    bc            = '0;
    bc.rec.mark   = 1'b0;
    bc.rec.price  = in_ch.price;
    bc.rec.id     = next_id_r;
    bc.rec.stamp  = in_ch.now_time;
    bc.rec.detail = {in_ch.rooms, in_ch.entry_day, in_ch.entry_month, in_ch.entry_year};
    bc.target     = in_ch.target_id;
    bc.now        = now_r;
    bc.window     = window_r;
  end

  // slot command for this cycle
  always_comb begin
    cmd.op       = OP_HOLD;
    cmd.clr_mark = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.mode == MODE_INSERT && !full) begin
          cmd.op = OP_INSERT;
        end else if (in_fire && in_ch.mode == MODE_RM_ID) begin
          cmd.op = OP_MARK_ID;
        end
      end
      S_DROP: begin
        cmd.op       = OP_DROP;
        cmd.clr_mark = 1'b1;
      end
      S_AGE:   cmd.op = OP_MARK_AGE;
      S_PURGE: cmd.op = OP_DROP;
      S_READ: begin
        if (read_step) begin
          cmd.op = desc_r ? OP_FROM_LEFT : OP_FROM_RIGHT;
        end
      end
      S_RESP: cmd.op = OP_HOLD;
    endcase
  end

  psrt_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .bc       (bc),
    .count    (count_r),
    .head     (head),
    .tail     (tail),
    .any_mark (any_mark)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_id_r   <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      // release the result word once taken, unless a new one loads below
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            purge_cnt_r <= '0;
            if (in_ch.mode == MODE_INSERT) begin
              if (full) begin
                resp_status_r <= ST_FULL;
                resp_id_r     <= '0;
              end else begin
                resp_status_r <= ST_OK;
                resp_id_r     <= next_id_r;
                count_r       <= count_r + CW'(1);
                next_id_r     <= (next_id_r >= ID_MAX) ? ID_W'(1) : next_id_r + ID_W'(1);
              end
              state_r <= S_RESP;
            end else if (in_ch.mode == MODE_RM_ID) begin
              resp_id_r <= in_ch.target_id;
              state_r   <= S_DROP;
            end else if (in_ch.mode == MODE_RM_AGE) begin
              window_r  <= WIN_W'(in_ch.days) * WIN_W'(SECS_PER_DAY);
              now_r     <= in_ch.now_time;
              resp_id_r <= '0;
              state_r   <= S_AGE;
            end else if (in_ch.mode == MODE_READ_UP || in_ch.mode == MODE_READ_DN) begin
              if (count_r == '0) begin
                resp_status_r <= ST_EMPTY;
                resp_id_r     <= '0;
                state_r       <= S_RESP;
              end else begin
                rot_r   <= '0;
                emit_r  <= '0;
                desc_r  <= (in_ch.mode == MODE_READ_DN);
                state_r <= S_READ;
              end
            end
          end
        end
        S_DROP: begin
          resp_status_r <= any_mark ? ST_OK : ST_NOT_FOUND;
          if (any_mark) begin
            count_r <= count_r - CW'(1);
          end
          state_r <= S_RESP;
        end
        S_AGE: begin
          state_r <= S_PURGE;
        end
        S_PURGE: begin
          // drop the first marked slot each cycle until none is left
          if (any_mark) begin
            count_r     <= count_r - CW'(1);
            purge_cnt_r <= purge_cnt_r + CW'(1);
          end else begin
            resp_status_r <= ST_OK;
            state_r       <= S_RESP;
          end
        end
        S_READ: begin
          if (read_step) begin
            if (tap_valid) begin
              out_valid_r   <= 1'b1;
              out_status_r  <= ST_OK;
              out_id_r      <= tap.id;
              out_price_r   <= tap.price;
              out_detail_r  <= tap.detail;
              out_stamp_r   <= tap.stamp;
              out_removed_r <= '0;
              out_last_r    <= (emit_r + CW'(1) == count_r);
              emit_r        <= emit_r + CW'(1);
            end
            rot_r <= rot_r + RW'(1);
            if (rot_r == RW'(DEPTH - 1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= resp_status_r;
            out_id_r      <= resp_id_r;
            out_price_r   <= '0;
            out_detail_r  <= '0;
            out_stamp_r   <= '0;
            out_removed_r <= REMOVED_W'(purge_cnt_r);
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.out_id        = out_id_r;
  assign out_ch.out_price     = out_price_r;
  assign out_ch.out_rooms     = out_detail_r[DETAIL_W-1 -: ROOMS_W];
  assign out_ch.out_day       = out_detail_r[MONTH_W+YEAR_W +: DAY_W];
  assign out_ch.out_month     = out_detail_r[YEAR_W +: MONTH_W];
  assign out_ch.out_year      = out_detail_r[YEAR_W-1:0];
  assign out_ch.out_stamp     = out_stamp_r;
  assign out_ch.removed_count = out_removed_r;
  assign out_ch.is_last       = out_last_r;

endmodule

### rtl/core/psrt_checker.sv
// Port-level checks for the price sorted record table, bound to the top level.
// Depends on psrt_pkg and price_sorted_record_table_macros.svh.
`include "price_sorted_record_table_macros.svh"

module psrt_checker import psrt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [MODE_W-1:0]   in_mode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [ID_W-1:0]     out_id,
  input logic                out_is_last
);

  // a stalled result word stays put
  `PSRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_id))

  // a real command closes the input once it is taken
  `PSRT_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, in_valid && in_ready && in_mode <= MODE_READ_DN, !in_ready)

  // empty-read answer is a lone word with no id
  `PSRT_ASSERT_NOW(a_empty_word, clk, rst_n, out_valid && out_status == ST_EMPTY, out_is_last && out_id == '0)

  // full-table answer uses no id
  `PSRT_ASSERT_NOW(a_full_word, clk, rst_n, out_valid && out_status == ST_FULL, out_is_last && out_id == '0)

endmodule

bind price_sorted_record_table psrt_checker u_psrt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_mode     (in_ch.mode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_id      (out_ch.out_id),
  .out_is_last (out_ch.is_last)
);
